// ===== hdl/yrf_pkg.sv =====
// Shared constants, types and color conversion functions for the YUYV to RGB block.
`timescale 1ns / 1ps

package yrf_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam int unsigned CFG_W  = 13;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned POS_W  = 12;
  localparam int unsigned COL_W  = ($clog2(MAX_WIDTH / 2) > 0) ? $clog2(MAX_WIDTH / 2) : 1;
  localparam int unsigned ROW_W  = ($clog2(MAX_HEIGHT) > 0) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned ACC_W  = 20;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [POS_W-1:0] dest_row;
    logic [POS_W-1:0] dest_column;
    logic             frame_end;
  } pos_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  localparam logic signed [ACC_W-1:0] K_Y    = ACC_W'(298);
  localparam logic signed [ACC_W-1:0] K_RV   = ACC_W'(409);
  localparam logic signed [ACC_W-1:0] K_GU   = ACC_W'(100);
  localparam logic signed [ACC_W-1:0] K_GV   = ACC_W'(208);
  localparam logic signed [ACC_W-1:0] K_BU   = ACC_W'(516);
  localparam logic signed [ACC_W-1:0] ROUND  = ACC_W'(128);
  localparam logic signed [9:0]       Y_OFS  = 10'sd16;
  localparam logic signed [9:0]       C_OFS  = 10'sd128;

  // Floor divide by 256, then saturate to one byte.
  function automatic logic [PIX_W-1:0] scale_clamp(logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] s;
    s = x >>> 8;
    if (s < 0) begin
      return '0;
    end else if (s > ACC_W'(255)) begin
      return '1;
    end
    return s[PIX_W-1:0];
  endfunction

  function automatic rgb_t yuv_to_rgb(logic [PIX_W-1:0] y, logic [PIX_W-1:0] u,
                                      logic [PIX_W-1:0] v);
    logic signed [9:0]       c;
    logic signed [9:0]       d;
    logic signed [9:0]       e;
    logic signed [ACC_W-1:0] cy;
    logic signed [ACC_W-1:0] du;
    logic signed [ACC_W-1:0] ev;
    rgb_t                    p;
    c  = $signed({2'b00, y}) - Y_OFS;
    d  = $signed({2'b00, u}) - C_OFS;
    e  = $signed({2'b00, v}) - C_OFS;
    cy = K_Y * ACC_W'(c);
    du = ACC_W'(d);
    ev = ACC_W'(e);
    p.red   = scale_clamp(cy + K_RV * ev + ROUND);
    p.green = scale_clamp(cy - K_GU * du - K_GV * ev + ROUND);
    p.blue  = scale_clamp(cy + K_BU * du + ROUND);
    return p;
  endfunction

endpackage

// ===== hdl/yrf_raster.sv =====
// Frame size registers and raster position counters.
`timescale 1ns / 1ps

module yrf_raster
  import yrf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             step_i,
  output pos_t             pos_o
);

  logic [CFG_W-1:0] width_q, width_d;
  logic [CFG_W-1:0] height_q, height_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  logic [CFG_W-1:0] w_even;
  logic [CFG_W-1:0] w_eff;
  logic [CFG_W-1:0] groups;
  logic [CFG_W-1:0] rows;
  logic [CFG_W-1:0] col_next;
  logic [CFG_W-1:0] row_next;
  logic             last_col;
  logic             last_row;
  logic             cfg_hit;

  // Effective frame geometry: even width saturated, zero sizes raised to minimum.
  always_comb begin
    w_even = {width_q[CFG_W-1:1], 1'b0};
    w_eff  = w_even;
    if (32'(w_even) > MAX_WIDTH) begin
      w_eff = CFG_W'(MAX_WIDTH & ~32'd1);
    end
    if (w_eff == '0) begin
      w_eff = CFG_W'(2);
    end
    groups = {1'b0, w_eff[CFG_W-1:1]};

    rows = height_q;
    if (32'(height_q) > MAX_HEIGHT) begin
      rows = CFG_W'(MAX_HEIGHT);
    end
    if (rows == '0) begin
      rows = CFG_W'(1);
    end
  end

  assign col_next = CFG_W'(col_q) + CFG_W'(1);
  assign row_next = CFG_W'(row_q) + CFG_W'(1);
  assign last_col = (col_next >= groups);
  assign last_row = (row_next >= rows);

  assign pos_o.dest_row    = POS_W'(rows - CFG_W'(1) - CFG_W'(row_q));
  assign pos_o.dest_column = POS_W'({col_q, 1'b0});
  assign pos_o.frame_end   = last_col & last_row;

  assign cfg_hit = cfg_we_i &&
                   ((cfg_index_i == REG_FRAME_WIDTH) || (cfg_index_i == REG_FRAME_HEIGHT));

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    if (cfg_hit) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:  width_d  = cfg_data_i;
        REG_FRAME_HEIGHT: height_d = cfg_data_i;
        default:          ;
      endcase
      // Restart the raster on any write to a mapped register.
      col_d = '0;
      row_d = '0;
    end else if (step_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_next[ROW_W-1:0];
      end else begin
        col_d = col_next[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

`ifndef SYNTHESIS
  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CFG_W'(col_q) < groups)
    else $error("column counter beyond row");

  a_row_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CFG_W'(row_q) < rows)
    else $error("row counter beyond frame");

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> (col_q == '0) && (row_q == '0))
    else $error("raster not restarted after register write");
`endif

endmodule

// ===== hdl/yuyv_to_rgb_flip_top.sv =====
// Top level: YUYV 4:2:2 group to two RGB888 pixels with vertically flipped position.
`timescale 1ns / 1ps
// Pipeline: input register, then result register, from input accept to result valid.
// Throughput: one beat per cycle; a new beat is taken every cycle while results drain.
// The color math is constant multiplies and clamps between the two registers.
// Reset: asynchronous, active low; clears both valid flags and the raster
// counters, and sets frame_width to 640 and frame_height to 480.

module yuyv_to_rgb_flip_top
  import yrf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,

  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,

  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [PIX_W-1:0] luma_first_i,
  input  logic [PIX_W-1:0] chroma_blue_i,
  input  logic [PIX_W-1:0] luma_second_i,
  input  logic [PIX_W-1:0] chroma_red_i,

  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PIX_W-1:0] red_first_o,
  output logic [PIX_W-1:0] green_first_o,
  output logic [PIX_W-1:0] blue_first_o,
  output logic [PIX_W-1:0] red_second_o,
  output logic [PIX_W-1:0] green_second_o,
  output logic [PIX_W-1:0] blue_second_o,
  output logic [POS_W-1:0] dest_row_o,
  output logic [POS_W-1:0] dest_column_o,
  output logic             frame_end_o
);

  // Input stage: raw bytes plus the raster position captured at accept.
  logic             s1_valid_q, s1_valid_d;
  logic [PIX_W-1:0] y0_q, u_q, y1_q, v_q;
  pos_t             s1_pos_q;

  // Result stage.
  logic             out_valid_q, out_valid_d;
  rgb_t             px0_q, px1_q;
  pos_t             out_pos_q;

  logic             in_fire;
  logic             s2_load;
  pos_t             cur_pos;
  rgb_t             px0, px1;

  // Load the result register when it is empty or being drained this cycle.
  assign s2_load    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s2_load;
  assign in_fire    = in_valid_i && in_ready_o;

  yrf_raster u_raster (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (in_fire),
    .pos_o       (cur_pos)
  );

  // Two pixels share the chroma pair.
  assign px0 = yuv_to_rgb(y0_q, u_q, v_q);
  assign px1 = yuv_to_rgb(y1_q, u_q, v_q);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s2_load) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (s2_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: capture on accept, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      y0_q     <= luma_first_i;
      u_q      <= chroma_blue_i;
      y1_q     <= luma_second_i;
      v_q      <= chroma_red_i;
      s1_pos_q <= cur_pos;
    end
    if (s2_load) begin
      px0_q     <= px0;
      px1_q     <= px1;
      out_pos_q <= s1_pos_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign red_first_o    = px0_q.red;
  assign green_first_o  = px0_q.green;
  assign blue_first_o   = px0_q.blue;
  assign red_second_o   = px1_q.red;
  assign green_second_o = px1_q.green;
  assign blue_second_o  = px1_q.blue;
  assign dest_row_o     = out_pos_q.dest_row;
  assign dest_column_o  = out_pos_q.dest_column;
  assign frame_end_o    = out_pos_q.frame_end;

`ifndef SYNTHESIS
  a_end_on_top_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |-> (dest_row_o == '0))
    else $error("frame end beat not on flipped top row");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled while a stage is free");

  a_no_lost_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_load && !in_fire) |=> s1_valid_q)
    else $error("input stage dropped a beat");
`endif

endmodule

// ===== bench/yuyv_rgb_checker.sv =====
// Result checker for the YUYV to RGB converter: predicts each pixel pair and compares it.
`timescale 1ns / 1ps

module yuyv_rgb_checker
  import yrf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,

  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,

  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [PIX_W-1:0] luma_first_i,
  input  logic [PIX_W-1:0] chroma_blue_i,
  input  logic [PIX_W-1:0] luma_second_i,
  input  logic [PIX_W-1:0] chroma_red_i,

  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [PIX_W-1:0] red_first_i,
  input  logic [PIX_W-1:0] green_first_i,
  input  logic [PIX_W-1:0] blue_first_i,
  input  logic [PIX_W-1:0] red_second_i,
  input  logic [PIX_W-1:0] green_second_i,
  input  logic [PIX_W-1:0] blue_second_i,
  input  logic [POS_W-1:0] dest_row_i,
  input  logic [POS_W-1:0] dest_column_i,
  input  logic             frame_end_i,

  output int               fail_count_o,
  output int               pending_o,
  output int               checked_o,
  output int               frame_ends_o
);

  typedef struct packed {
    logic [PIX_W-1:0] red_first;
    logic [PIX_W-1:0] green_first;
    logic [PIX_W-1:0] blue_first;
    logic [PIX_W-1:0] red_second;
    logic [PIX_W-1:0] green_second;
    logic [PIX_W-1:0] blue_second;
    logic [POS_W-1:0] dest_row;
    logic [POS_W-1:0] dest_column;
    logic             frame_end;
  } rgb_pair_t;

  logic [CFG_W-1:0] width_reg  = WIDTH_RESET;
  logic [CFG_W-1:0] height_reg = HEIGHT_RESET;
  int unsigned      col_pair   = 0;
  int unsigned      src_row    = 0;
  rgb_pair_t        pairs_due[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
    frame_ends_o = 0;
  end

  // Floor by 256 (int shifts arithmetically), then saturate to a byte.
  function automatic logic [PIX_W-1:0] shift_clamp(int acc);
    int q;
    q = acc >>> 8;
    if (q < 0) return '0;
    if (q > 255) return '1;
    return q[PIX_W-1:0];
  endfunction

  function automatic logic [3*PIX_W-1:0] to_rgb(logic [PIX_W-1:0] y, logic [PIX_W-1:0] u,
                                                logic [PIX_W-1:0] v);
    int c;
    int d;
    int e;
    c = int'(y) - 16;
    d = int'(u) - 128;
    e = int'(v) - 128;
    return {shift_clamp(298 * c + 409 * e + 128),
            shift_clamp(298 * c - 100 * d - 208 * e + 128),
            shift_clamp(298 * c + 516 * d + 128)};
  endfunction

  function automatic int unsigned row_groups(logic [CFG_W-1:0] w_cfg);
    int unsigned w;
    w = w_cfg & 13'h1FFE;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (w == 0) w = 2;
    return w / 2;
  endfunction

  function automatic int unsigned frame_rows(logic [CFG_W-1:0] h_cfg);
    int unsigned h;
    h = h_cfg;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    if (h == 0) h = 1;
    return h;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    rgb_pair_t   p;
    rgb_pair_t   q;
    int unsigned groups;
    int unsigned rows;
    logic        col_end;
    logic        row_end;
    if (!rst_ni) begin
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      col_pair   = 0;
      src_row    = 0;
      pairs_due.delete();
    end else begin
      // Check the outgoing beat first: a beat taken at this edge cannot leave at it.
      if (out_valid_i && out_ready_i) begin
        if (pairs_due.size() == 0) begin
          $error("result beat with no pending prediction");
          fail_count_o++;
        end else begin
          q = pairs_due.pop_front();
          check_field("red_first", q.red_first, red_first_i);
          check_field("green_first", q.green_first, green_first_i);
          check_field("blue_first", q.blue_first, blue_first_i);
          check_field("red_second", q.red_second, red_second_i);
          check_field("green_second", q.green_second, green_second_i);
          check_field("blue_second", q.blue_second, blue_second_i);
          check_field("dest_row", q.dest_row, dest_row_i);
          check_field("dest_column", q.dest_column, dest_column_i);
          check_field("frame_end", q.frame_end, frame_end_i);
        end
        checked_o++;
        if (frame_end_i) frame_ends_o++;
      end

      if (cfg_we_i) begin
        // Any mapped write restarts the raster; unmapped indexes are dropped.
        case (cfg_index_i)
          REG_FRAME_WIDTH: begin
            width_reg = cfg_data_i;
            col_pair  = 0;
            src_row   = 0;
          end
          REG_FRAME_HEIGHT: begin
            height_reg = cfg_data_i;
            col_pair   = 0;
            src_row    = 0;
          end
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        groups  = row_groups(width_reg);
        rows    = frame_rows(height_reg);
        col_end = (col_pair + 1 >= groups);
        row_end = (src_row + 1 >= rows);
        {p.red_first, p.green_first, p.blue_first} =
            to_rgb(luma_first_i, chroma_blue_i, chroma_red_i);
        {p.red_second, p.green_second, p.blue_second} =
            to_rgb(luma_second_i, chroma_blue_i, chroma_red_i);
        p.dest_row    = POS_W'(rows - 1 - src_row);
        p.dest_column = POS_W'(col_pair * 2);
        p.frame_end   = col_end && row_end;
        pairs_due.push_back(p);
        if (col_end) begin
          col_pair = 0;
          src_row  = row_end ? 0 : src_row + 1;
        end else begin
          col_pair++;
        end
      end
    end
    pending_o = pairs_due.size();
  end

endmodule

// ===== bench/tb_yuyv_to_rgb_flip_top.sv =====
// Testbench top: drives YUYV beats and register writes, stalls the result side, gives the verdict.
`timescale 1ns / 1ps

module tb_yuyv_to_rgb_flip_top;
  import yrf_pkg::*;

  // Indexes the register map leaves unused; writes there must change nothing.
  localparam logic [IDX_W-1:0] REG_SPARE_LO = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_SPARE_HI = IDX_W'(3);

  localparam int GROUP_TARGET = 1900;
  // Longest receiver hold-off, in cycles.
  localparam int HOLD_CYCLES  = 120;
  // Cycles without any beat or write before the run is declared hung. The slowest
  // correct stretch is the hold-off above plus the two-stage pipeline, so this
  // leaves a wide margin over sender gaps and receiver stall patterns.
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 8;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_PATTERN
  } ready_mode_e;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [PIX_W-1:0] luma_first_i;
  logic [PIX_W-1:0] chroma_blue_i;
  logic [PIX_W-1:0] luma_second_i;
  logic [PIX_W-1:0] chroma_red_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [PIX_W-1:0] red_first_o;
  logic [PIX_W-1:0] green_first_o;
  logic [PIX_W-1:0] blue_first_o;
  logic [PIX_W-1:0] red_second_o;
  logic [PIX_W-1:0] green_second_o;
  logic [PIX_W-1:0] blue_second_o;
  logic [POS_W-1:0] dest_row_o;
  logic [POS_W-1:0] dest_column_o;
  logic             frame_end_o;

  int fail_count;
  int pending;
  int checked;
  int frame_ends;

  int   burst_left    = 0;
  int   groups_sent   = 0;
  int   geometries    = 0;
  int   stall_cycles  = 0;
  logic choke_req     = 1'b0;
  logic choke_done    = 1'b0;

  // Corner groups, packed as {Y0, U, Y1, V}: all-zero and all-ones bytes,
  // studio black and white, saturating chroma both ways, and mixed extremes.
  logic [31:0] corner_groups [0:11] = '{
    32'h00000000, 32'hFFFFFFFF, 32'h10801080, 32'hEB80EB80,
    32'h00FFFF00, 32'hFF0000FF, 32'h8000_80FF, 32'h80FF8000,
    32'h515A29F0, 32'h0080FF80, 32'h1000EBFF, 32'hFF800080
  };

  yuyv_to_rgb_flip_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .luma_first_i   (luma_first_i),
    .chroma_blue_i  (chroma_blue_i),
    .luma_second_i  (luma_second_i),
    .chroma_red_i   (chroma_red_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .red_first_o    (red_first_o),
    .green_first_o  (green_first_o),
    .blue_first_o   (blue_first_o),
    .red_second_o   (red_second_o),
    .green_second_o (green_second_o),
    .blue_second_o  (blue_second_o),
    .dest_row_o     (dest_row_o),
    .dest_column_o  (dest_column_o),
    .frame_end_o    (frame_end_o)
  );

  yuyv_rgb_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .luma_first_i   (luma_first_i),
    .chroma_blue_i  (chroma_blue_i),
    .luma_second_i  (luma_second_i),
    .chroma_red_i   (chroma_red_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .red_first_i    (red_first_o),
    .green_first_i  (green_first_o),
    .blue_first_i   (blue_first_o),
    .red_second_i   (red_second_o),
    .green_second_i (green_second_o),
    .blue_second_i  (blue_second_o),
    .dest_row_i     (dest_row_o),
    .dest_column_i  (dest_column_o),
    .frame_end_i    (frame_end_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .frame_ends_o   (frame_ends)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Offer one group and hold it until the block takes it. Between bursts, drop
  // valid for a random gap; skip gaps while the receiver is being choked so the
  // pipeline really fills up.
  task automatic send_group(input logic [PIX_W-1:0] y0, input logic [PIX_W-1:0] u,
                            input logic [PIX_W-1:0] y1, input logic [PIX_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ((choke_req && !choke_done) || $urandom_range(0, 3) == 0) ? 0
                                                                       : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i    <= 1'b1;
    luma_first_i  <= y0;
    chroma_blue_i <= u;
    luma_second_i <= y1;
    chroma_red_i  <= v;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    groups_sent++;
  endtask

  task automatic send_random(input int count);
    repeat (count) begin
      send_group(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                 PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)));
    end
  endtask

  // Drop valid and wait until every predicted pair has come out; the block is
  // idle then, since each group yields exactly one pair.
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Hold write enable high across back-to-back writes; close_program lowers it.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
  endtask

  task automatic close_program();
    cfg_we_i <= 1'b0;
    geometries++;
  endtask

  // Receiver: change stall pattern every so often; once, on request, hold off
  // long enough to back the block up into its input.
  initial begin : receiver
    ready_mode_e mode;
    int          span;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (choke_req && !choke_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        choke_done = 1'b1;
      end else begin
        mode = ready_mode_e'($urandom_range(0, 3));
        span = $urandom_range(8, 150);
        for (int k = 0; k < span; k++) begin
          case (mode)
            READY_ALWAYS: out_ready_i <= 1'b1;
            READY_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
            READY_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
            default:      out_ready_i <= (k % 3 != 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // Watchdog: any beat or register write counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    int               pick;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= REG_FRAME_WIDTH;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    luma_first_i  <= '0;
    chroma_blue_i <= '0;
    luma_second_i <= '0;
    chroma_red_i  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corner pixel values under the reset geometry of 640 x 480.
    foreach (corner_groups[i]) begin
      send_group(corner_groups[i][31:24], corner_groups[i][23:16],
                 corner_groups[i][15:8], corner_groups[i][7:0]);
    end
    settle();

    // Width and height of zero: one group per frame, every beat ends a frame.
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, '0);
    close_program();
    send_random(2);
    settle();

    // Odd width of one rounds down to nothing and is taken as one group per row.
    write_reg(REG_FRAME_WIDTH, CFG_W'(1));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(3));
    close_program();
    send_random(3);
    settle();

    // Both registers at full scale: saturate to the maximum frame.
    write_reg(REG_FRAME_WIDTH, '1);
    write_reg(REG_FRAME_HEIGHT, '1);
    close_program();
    send_random(3);
    settle();

    // Rewrite height alone in mid-row: raster must restart at the top.
    write_reg(REG_FRAME_WIDTH, CFG_W'(6));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(2));
    close_program();
    send_random(2);
    settle();
    write_reg(REG_FRAME_HEIGHT, CFG_W'(3));
    close_program();
    send_random(2);
    settle();

    // Write to an unmapped index: raster keeps going where it was.
    write_reg(REG_SPARE_HI, '1);
    cfg_we_i <= 1'b0;
    send_random(1);
    settle();

    // Back-pressure run: the receiver holds off while groups keep coming.
    write_reg(REG_FRAME_WIDTH, CFG_W'(10));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(4));
    close_program();
    choke_req = 1'b1;
    send_random(250);
    settle();

    // Random geometries: mostly small frames so frame ends come often, with an
    // occasional width or height just below, at or past the maximum.
    while (groups_sent < GROUP_TARGET) begin
      w = CFG_W'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 24)
                                             : $urandom_range(MAX_WIDTH - 2, 8191));
      h = CFG_W'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 6)
                                             : $urandom_range(MAX_HEIGHT - 1, 8191));
      pick = $urandom_range(0, 3);
      if (pick != 2) write_reg(REG_FRAME_WIDTH, w);
      if (pick != 1) write_reg(REG_FRAME_HEIGHT, h);
      if (pick == 3) write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_LO : REG_SPARE_HI,
                               CFG_W'($urandom_range(0, 8191)));
      close_program();
      send_random($urandom_range(10, 100));
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending != 0) begin
      $error("%0d predicted pairs never came out", pending);
    end

    $display("Sent %0d YUYV groups over %0d frame geometries, one long receiver hold-off.",
             groups_sent, geometries);
    $display("Compared %0d RGB pairs, %0d of them closing a frame.", checked, frame_ends);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/yrf_pkg.sv
hdl/yrf_raster.sv
hdl/yuyv_to_rgb_flip_top.sv
bench/yuyv_rgb_checker.sv
bench/tb_yuyv_to_rgb_flip_top.sv
